>>> sv/chc_pkg.sv
`timescale 1ns / 1ps
// Shared types, address map, result codes and logo table for the cartridge
// header checker. No dependencies.
package chc_pkg;

    // Header address map
    localparam logic [8:0] ADDR_LOGO_START = 9'h104;
    localparam int unsigned LOGO_LEN       = 48;
    localparam logic [8:0] ADDR_LOGO_END   = 9'h133;
    localparam logic [8:0] ADDR_SUM_START  = 9'h134;
    localparam logic [8:0] ADDR_SUM_END    = 9'h14C;
    localparam logic [8:0] ADDR_FEATURE    = 9'h143;
    localparam logic [8:0] ADDR_SUPER      = 9'h146;
    localparam logic [8:0] ADDR_TYPE       = 9'h147;
    localparam logic [8:0] ADDR_ROM_SIZE   = 9'h148;
    localparam logic [8:0] ADDR_RAM_SIZE   = 9'h149;
    localparam logic [8:0] ADDR_DEST       = 9'h14A;
    localparam logic [8:0] ADDR_VERSION    = 9'h14C;
    localparam logic [8:0] ADDR_CHECKSUM   = 9'h14D;

    localparam logic [7:0] COLOR_FLAG_MASK = 8'h80;
    localparam logic [7:0] COLOR_EXCL_MASK = 8'hC0;
    localparam logic [7:0] SUPER_CODE      = 8'h03;

    // Cartridge type bytes and kinds
    localparam logic [7:0] TYPE_ROM_ONLY  = 8'h00;
    localparam logic [7:0] TYPE_MBC1      = 8'h01;
    localparam logic [7:0] TYPE_MBC3_RB   = 8'h13;
    localparam logic [7:0] TYPE_MBC5_RB   = 8'h1B;
    localparam logic [2:0] CART_ROM_ONLY  = 3'd0;
    localparam logic [2:0] CART_MBC1      = 3'd1;
    localparam logic [2:0] CART_MBC3_RB   = 3'd2;
    localparam logic [2:0] CART_MBC5_RB   = 3'd3;
    localparam logic [2:0] CART_UNSUPP    = 3'd4;

    // ROM size
    localparam logic [7:0] ROM_SIZE_MAX   = 8'd8;
    localparam logic [3:0] ROM_UNSUPP     = 4'd9;

    // RAM size bytes and kinds
    localparam logic [7:0] RAM_B_NONE     = 8'h00;
    localparam logic [7:0] RAM_B_2K       = 8'h01;
    localparam logic [7:0] RAM_B_8K       = 8'h02;
    localparam logic [7:0] RAM_B_32K      = 8'h03;
    localparam logic [7:0] RAM_B_128K     = 8'h04;
    localparam logic [7:0] RAM_B_64K      = 8'h05;
    localparam logic [2:0] RAM_NONE       = 3'd0;
    localparam logic [2:0] RAM_2K         = 3'd1;
    localparam logic [2:0] RAM_8K         = 3'd2;
    localparam logic [2:0] RAM_32K        = 3'd3;
    localparam logic [2:0] RAM_64K        = 3'd4;
    localparam logic [2:0] RAM_128K       = 3'd5;
    localparam logic [2:0] RAM_UNSUPP     = 3'd6;

    localparam logic [7:0] DEST_MAX       = 8'd1;

    localparam logic [7:0] LOGO_TABLE [LOGO_LEN] = '{
        8'hCE, 8'hED, 8'h66, 8'h66, 8'hCC, 8'h0D, 8'h00, 8'h0B,
        8'h03, 8'h73, 8'h00, 8'h83, 8'h00, 8'h0C, 8'h00, 8'h0D,
        8'h00, 8'h08, 8'h11, 8'h1F, 8'h88, 8'h89, 8'h00, 8'h0E,
        8'hDC, 8'hCC, 8'h6E, 8'hE6, 8'hDD, 8'hDD, 8'hD9, 8'h99,
        8'hBB, 8'hBB, 8'h67, 8'h63, 8'h6E, 8'h0E, 8'hEC, 8'hCC,
        8'hDD, 8'hDC, 8'h99, 8'h9F, 8'hBB, 8'hB9, 8'h33, 8'h3E
    };

    // Running header state
    typedef struct packed {
        logic       logo_match;
        logic [7:0] check_acc;
        logic [7:0] stored_checksum;
        logic [7:0] feature_byte;
        logic [7:0] super_byte;
        logic [7:0] type_byte;
        logic [7:0] rom_size_byte;
        logic [7:0] ram_size_byte;
        logic [7:0] dest_byte;
        logic [7:0] version_byte;
    } t_hdr_state;

    localparam t_hdr_state HDR_STATE_RESET = '{
        logo_match: 1'b1, check_acc: 8'h00, stored_checksum: 8'h00,
        feature_byte: 8'h00, super_byte: 8'h00, type_byte: 8'h00,
        rom_size_byte: 8'h00, ram_size_byte: 8'h00, dest_byte: 8'h00,
        version_byte: 8'h00
    };

    // Decoded result, packed in output word order (MSB first here)
    typedef struct packed {
        logic       cart_supported;
        logic [7:0] version_number;
        logic [7:0] destination_code;
        logic [2:0] ram_size_kind;
        logic [3:0] rom_size_kind;
        logic [2:0] cart_kind;
        logic       super_supported;
        logic       color_exclusive;
        logic       color_supported;
        logic       checksum_valid;
        logic       logo_valid;
    } t_result;

endpackage

>>> sv/chc_accum.sv
`timescale 1ns / 1ps
// Header state registers: logo compare, running checksum and byte capture.
// Depends on chc_pkg.
module chc_accum import chc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,      // non-end word accepted
    input  logic       i_clear,     // end word accepted
    input  logic [8:0] i_addr,
    input  logic [7:0] i_value,
    output t_hdr_state o_state
);

    t_hdr_state r_state;
    t_hdr_state n_state;
    logic [8:0] logo_off;
    logic       in_logo;
    logic       in_sum;

    assign logo_off = i_addr - ADDR_LOGO_START;
    assign in_logo  = (i_addr >= ADDR_LOGO_START) && (i_addr <= ADDR_LOGO_END);
    assign in_sum   = (i_addr >= ADDR_SUM_START) && (i_addr <= ADDR_SUM_END);

    always_comb begin
        n_state = r_state;
        if (in_logo && (i_value != LOGO_TABLE[logo_off[5:0]])) begin
            n_state.logo_match = 1'b0;
        end
        // acc - v - 1 == acc + ~v (mod 256)
        if (in_sum) begin
            n_state.check_acc = r_state.check_acc + ~i_value;
        end
        unique case (i_addr)
            ADDR_FEATURE:  n_state.feature_byte    = i_value;
            ADDR_SUPER:    n_state.super_byte      = i_value;
            ADDR_TYPE:     n_state.type_byte       = i_value;
            ADDR_ROM_SIZE: n_state.rom_size_byte   = i_value;
            ADDR_RAM_SIZE: n_state.ram_size_byte   = i_value;
            ADDR_DEST:     n_state.dest_byte       = i_value;
            ADDR_VERSION:  n_state.version_byte    = i_value;
            ADDR_CHECKSUM: n_state.stored_checksum = i_value;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_state <= HDR_STATE_RESET;
        end else if (i_load) begin
            r_state <= n_state;
        end
    end

    assign o_state = r_state;

endmodule

>>> sv/chc_decode.sv
`timescale 1ns / 1ps
// Turns the collected header state into the result fields.
// Depends on chc_pkg.
module chc_decode import chc_pkg::*; (
    input  t_hdr_state i_state,
    output t_result    o_result
);

    logic [2:0] cart_k;
    logic [3:0] rom_k;
    logic [2:0] ram_k;

    always_comb begin
        unique case (i_state.type_byte)
            TYPE_ROM_ONLY: cart_k = CART_ROM_ONLY;
            TYPE_MBC1:     cart_k = CART_MBC1;
            TYPE_MBC3_RB:  cart_k = CART_MBC3_RB;
            TYPE_MBC5_RB:  cart_k = CART_MBC5_RB;
            default:       cart_k = CART_UNSUPP;
        endcase
        unique case (i_state.ram_size_byte)
            RAM_B_NONE: ram_k = RAM_NONE;
            RAM_B_2K:   ram_k = RAM_2K;
            RAM_B_8K:   ram_k = RAM_8K;
            RAM_B_32K:  ram_k = RAM_32K;
            RAM_B_128K: ram_k = RAM_128K;
            RAM_B_64K:  ram_k = RAM_64K;
            default:    ram_k = RAM_UNSUPP;
        endcase
        rom_k = (i_state.rom_size_byte <= ROM_SIZE_MAX) ? i_state.rom_size_byte[3:0]
                                                        : ROM_UNSUPP;
    end

    always_comb begin
        o_result.logo_valid       = i_state.logo_match;
        o_result.checksum_valid   = (i_state.stored_checksum == i_state.check_acc);
        o_result.color_supported  = |(i_state.feature_byte & COLOR_FLAG_MASK);
        o_result.color_exclusive  =
            ((i_state.feature_byte & COLOR_EXCL_MASK) == COLOR_EXCL_MASK);
        o_result.super_supported  = (i_state.super_byte == SUPER_CODE);
        o_result.cart_kind        = cart_k;
        o_result.rom_size_kind    = rom_k;
        o_result.ram_size_kind    = ram_k;
        o_result.destination_code = i_state.dest_byte;
        o_result.version_number   = i_state.version_byte;
        o_result.cart_supported   = (cart_k != CART_UNSUPP) && (rom_k != ROM_UNSUPP)
                                  && (ram_k != RAM_UNSUPP)
                                  && (i_state.dest_byte <= DEST_MAX);
    end

endmodule

>>> sv/cartridge_header_checker.sv
`timescale 1ns / 1ps
// Cartridge header checker: takes one header byte per word with its ROM
// address, and on a word with tlast set returns one 32-bit result word with
// logo/checksum validity and the decoded cartridge fields, then clears itself
// for the next header. It accepts one word every cycle; the result appears on
// the master side the cycle after the tlast word is taken, from a single
// output register. Input words stall only while that register holds a result
// that the sink has not taken. The address and byte of a tlast word are
// ignored. Bytes at 0x104..0x133 are compared with the fixed logo, bytes at
// 0x134..0x14C feed the checksum (acc - byte - 1), and repeated addresses are
// processed again. Depends on chc_pkg, chc_accum and chc_decode.
module cartridge_header_checker import chc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side: tdata = byte_address[8:0], byte_value[16:9], zero pad [23:17]
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,
    input  logic        i_s_axis_tlast,     // end_of_header
    // master side: tdata = logo_valid[0], checksum_valid[1], color_supported[2],
    // color_exclusive[3], super_supported[4], cart_kind[7:5],
    // rom_size_kind[11:8], ram_size_kind[14:12], destination_code[22:15],
    // version_number[30:23], cart_supported[31]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata
);

    logic       s_accept;
    logic       end_word;
    t_hdr_state hdr_state;
    t_result    result;

    logic       r_out_valid;
    t_result    r_out_data;

    // Output register frees up in the same cycle it is drained.
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign end_word        = s_accept && i_s_axis_tlast;

    chc_accum u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (s_accept && !i_s_axis_tlast),
        .i_clear (end_word),
        .i_addr  (i_s_axis_tdata[8:0]),
        .i_value (i_s_axis_tdata[16:9]),
        .o_state (hdr_state)
    );

    chc_decode u_decode (
        .i_state  (hdr_state),
        .o_result (result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (end_word) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (end_word) begin
            r_out_data <= result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // An end word always leaves a result behind it.
    a_end_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        end_word |=> o_m_axis_tvalid)
        else $error("no result after end word");

    // An end word returns the header state to its reset values.
    a_end_clears_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        end_word |=> (hdr_state == HDR_STATE_RESET))
        else $error("header state not cleared after end word");

    // Plain header bytes never create a result.
    a_no_spurious_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_m_axis_tvalid && !end_word) |=> !o_m_axis_tvalid)
        else $error("result without end word");

    // Supported flag only with cart, ROM size and RAM size kinds all supported.
    a_supported_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && r_out_data.cart_supported) |->
            (r_out_data.cart_kind != CART_UNSUPP)
            && (r_out_data.rom_size_kind != ROM_UNSUPP)
            && (r_out_data.ram_size_kind != RAM_UNSUPP))
        else $error("cart_supported with unsupported field");

    // Exclusive color implies color support.
    a_color_implied: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && r_out_data.color_exclusive) |-> r_out_data.color_supported)
        else $error("color_exclusive without color_supported");

endmodule

>>> tb/tb_cartridge_header_checker.sv
`timescale 1ns / 1ps
// Self-checking bench for cartridge_header_checker: a directed table of header words,
// then random whole and partial headers, scored against a built-in predictor or a written-out verdict.
// Depends on chc_pkg and the checker RTL.
module tb_cartridge_header_checker;
    import chc_pkg::*;

    localparam int unsigned HDR_SPAN     = 74;     // 0x104..0x14D
    localparam int unsigned QUIET_LIMIT  = 1000;   // cycles with no word moved
    localparam int unsigned ITEM_TARGET  = 1100;   // closing stretch adds about 300

    typedef struct packed {
        logic [8:0] addr;
        logic [7:0] val;
        logic       last;
        logic       typed;   // 1: use the written-out verdict below
        t_result    want;
    } t_dir_row;

    localparam int unsigned N_DIR = 25;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [23:0] s_data = '0;
    logic        s_last = 1'b0;
    logic        m_ready = 1'b1;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [31:0] o_m_axis_tdata;

    t_hdr_state  shadow = HDR_STATE_RESET;
    t_result     pending_verdicts [$];
    int unsigned gap_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned n_items = 0;
    int unsigned n_errors = 0;
    int unsigned quiet_cycles = 0;

    // Directed table: reset state, all-ones extremes, then a supported header
    // with ignored addresses mixed in and a payload on the tlast word.
    t_dir_row dir_tab [N_DIR] = '{
        '{9'h000, 8'h00, 1'b1, 1'b1,
          t_result'{1'b1, 8'h00, 8'h00, RAM_NONE, 4'd0, CART_ROM_ONLY,
                    1'b0, 1'b0, 1'b0, 1'b1, 1'b1}},
        '{9'h104, 8'h00, 1'b0, 1'b0, '0},    // logo mismatch
        '{9'h143, 8'hFF, 1'b0, 1'b0, '0},
        '{9'h146, 8'h03, 1'b0, 1'b0, '0},
        '{9'h147, 8'hFF, 1'b0, 1'b0, '0},
        '{9'h148, 8'hFF, 1'b0, 1'b0, '0},
        '{9'h149, 8'hFF, 1'b0, 1'b0, '0},
        '{9'h14A, 8'hFF, 1'b0, 1'b0, '0},
        '{9'h14C, 8'hFF, 1'b0, 1'b0, '0},
        '{9'h14D, 8'hFC, 1'b0, 1'b0, '0},    // matches the running sum
        '{9'h1FF, 8'hFF, 1'b1, 1'b1,
          t_result'{1'b0, 8'hFF, 8'hFF, RAM_UNSUPP, ROM_UNSUPP, CART_UNSUPP,
                    1'b1, 1'b1, 1'b1, 1'b1, 1'b0}},
        '{9'h133, 8'h3E, 1'b0, 1'b0, '0},
        '{9'h104, 8'hCE, 1'b0, 1'b0, '0},
        '{9'h143, 8'h80, 1'b0, 1'b0, '0},
        '{9'h146, 8'h02, 1'b0, 1'b0, '0},
        '{9'h147, 8'h1B, 1'b0, 1'b0, '0},
        '{9'h148, 8'h08, 1'b0, 1'b0, '0},
        '{9'h149, 8'h04, 1'b0, 1'b0, '0},
        '{9'h14A, 8'h01, 1'b0, 1'b0, '0},
        '{9'h14C, 8'h00, 1'b0, 1'b0, '0},
        '{9'h000, 8'hFF, 1'b0, 1'b0, '0},    // below the header
        '{9'h14E, 8'h12, 1'b0, 1'b0, '0},
        '{9'h1FF, 8'h00, 1'b0, 1'b0, '0},
        '{9'h14D, 8'h55, 1'b0, 1'b0, '0},
        '{9'h0A5, 8'h5A, 1'b1, 1'b0, '0}
    };

    cartridge_header_checker uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_result header_verdict(input t_hdr_state st);
        t_result r;
        r = '0;
        r.logo_valid      = st.logo_match;
        r.checksum_valid  = (st.stored_checksum == st.check_acc);
        r.color_supported = st.feature_byte[7];
        r.color_exclusive = &st.feature_byte[7:6];
        r.super_supported = (st.super_byte == SUPER_CODE);
        case (st.type_byte)
            TYPE_ROM_ONLY: r.cart_kind = CART_ROM_ONLY;
            TYPE_MBC1:     r.cart_kind = CART_MBC1;
            TYPE_MBC3_RB:  r.cart_kind = CART_MBC3_RB;
            TYPE_MBC5_RB:  r.cart_kind = CART_MBC5_RB;
            default:       r.cart_kind = CART_UNSUPP;
        endcase
        r.rom_size_kind = (st.rom_size_byte <= ROM_SIZE_MAX) ? st.rom_size_byte[3:0]
                                                             : ROM_UNSUPP;
        case (st.ram_size_byte)
            RAM_B_NONE: r.ram_size_kind = RAM_NONE;
            RAM_B_2K:   r.ram_size_kind = RAM_2K;
            RAM_B_8K:   r.ram_size_kind = RAM_8K;
            RAM_B_32K:  r.ram_size_kind = RAM_32K;
            RAM_B_128K: r.ram_size_kind = RAM_128K;
            RAM_B_64K:  r.ram_size_kind = RAM_64K;
            default:    r.ram_size_kind = RAM_UNSUPP;
        endcase
        r.destination_code = st.dest_byte;
        r.version_number   = st.version_byte;
        r.cart_supported   = (r.cart_kind != CART_UNSUPP) && (r.rom_size_kind != ROM_UNSUPP)
                             && (r.ram_size_kind != RAM_UNSUPP) && (st.dest_byte <= DEST_MAX);
        return r;
    endfunction

    // Fold one accepted word into the shadow state; tlast queues a verdict.
    task automatic absorb_header_word(input logic [8:0] addr, input logic [7:0] val,
                                      input logic last, input logic typed,
                                      input t_result want);
        logic [8:0] off;
        off = addr - ADDR_LOGO_START;
        if (last) begin
            pending_verdicts.push_back(typed ? want : header_verdict(shadow));
            shadow = HDR_STATE_RESET;
        end else begin
            if (addr >= ADDR_LOGO_START && addr <= ADDR_LOGO_END)
                if (val != LOGO_TABLE[off[5:0]])
                    shadow.logo_match = 1'b0;
            if (addr >= ADDR_SUM_START && addr <= ADDR_SUM_END)
                shadow.check_acc = shadow.check_acc - val - 8'd1;
            case (addr)
                ADDR_FEATURE:  shadow.feature_byte    = val;
                ADDR_SUPER:    shadow.super_byte      = val;
                ADDR_TYPE:     shadow.type_byte       = val;
                ADDR_ROM_SIZE: shadow.rom_size_byte   = val;
                ADDR_RAM_SIZE: shadow.ram_size_byte   = val;
                ADDR_DEST:     shadow.dest_byte       = val;
                ADDR_VERSION:  shadow.version_byte    = val;
                ADDR_CHECKSUM: shadow.stored_checksum = val;
                default: ;
            endcase
        end
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_word(input logic [8:0] addr, input logic [7:0] val,
                             input logic last, input logic typed, input t_result want);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= {7'd0, val, addr};
        s_last  <= last;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        absorb_header_word(addr, val, last, typed, want);
        n_items++;
        @(negedge i_clk);
    endtask

    // One header: with full set, a full, ordered image, mostly with a sane logo and
    // checksum; otherwise a short scrap of random addresses. Always closed by tlast.
    task automatic send_random_header(input bit full);
        logic [7:0] img [HDR_SPAN];
        logic [7:0] acc;
        int unsigned n;
        int unsigned k;
        for (int i = 0; i < HDR_SPAN; i++)
            img[i] = (i < LOGO_LEN) ? LOGO_TABLE[i] : 8'($urandom_range(0, 255));
        if ($urandom_range(0, 4) == 0)
            img[$urandom_range(0, LOGO_LEN - 1)] = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 4))
            0: img[ADDR_FEATURE - ADDR_LOGO_START] = 8'h00;
            1: img[ADDR_FEATURE - ADDR_LOGO_START] = COLOR_FLAG_MASK;
            2: img[ADDR_FEATURE - ADDR_LOGO_START] = COLOR_EXCL_MASK;
            3: img[ADDR_FEATURE - ADDR_LOGO_START] = 8'h40;
            default: ;
        endcase
        if ($urandom_range(0, 1) == 0)
            img[ADDR_SUPER - ADDR_LOGO_START] = SUPER_CODE;
        case ($urandom_range(0, 4))
            0: img[ADDR_TYPE - ADDR_LOGO_START] = TYPE_ROM_ONLY;
            1: img[ADDR_TYPE - ADDR_LOGO_START] = TYPE_MBC1;
            2: img[ADDR_TYPE - ADDR_LOGO_START] = TYPE_MBC3_RB;
            3: img[ADDR_TYPE - ADDR_LOGO_START] = TYPE_MBC5_RB;
            default: ;
        endcase
        if ($urandom_range(0, 3) != 0)
            img[ADDR_ROM_SIZE - ADDR_LOGO_START] = 8'($urandom_range(0, 9));
        if ($urandom_range(0, 3) != 0)
            img[ADDR_RAM_SIZE - ADDR_LOGO_START] = 8'($urandom_range(0, 6));
        if ($urandom_range(0, 2) != 0)
            img[ADDR_DEST - ADDR_LOGO_START] = 8'($urandom_range(0, 1));
        acc = 8'h00;
        for (int i = ADDR_SUM_START - ADDR_LOGO_START; i <= ADDR_SUM_END - ADDR_LOGO_START; i++)
            acc = acc - img[i] - 8'd1;
        if ($urandom_range(0, 5) != 0)
            img[ADDR_CHECKSUM - ADDR_LOGO_START] = acc;

        if (full) begin
            for (int i = 0; i < HDR_SPAN; i++) begin
                if ($urandom_range(0, 39) != 0)
                    send_word(ADDR_LOGO_START + 9'(i), img[i], 1'b0, 1'b0, '0);
                if ($urandom_range(0, 29) == 0)
                    send_word(9'($urandom_range(0, 511)), 8'($urandom_range(0, 255)),
                              1'b0, 1'b0, '0);
            end
        end else begin
            n = $urandom_range(0, 20);
            repeat (n) begin
                k = $urandom_range(0, HDR_SPAN - 1);
                if ($urandom_range(0, 1) == 0)
                    send_word(ADDR_LOGO_START + 9'(k), img[k], 1'b0, 1'b0, '0);
                else
                    send_word(9'($urandom_range(0, 511)), 8'($urandom_range(0, 255)),
                              1'b0, 1'b0, '0);
            end
        end
        send_word(9'($urandom_range(0, 511)), 8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            n_errors++;
        end
    endtask

    // Result side: bursty back-pressure on the master port.
    initial begin
        forever begin
            @(negedge i_clk);
            if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(negedge i_clk);
            end
            m_ready <= 1'b1;
        end
    end

    // Score every result word against the oldest queued verdict.
    t_result got_word;
    t_result want_word;
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && m_ready) begin
            got_word = t_result'(o_m_axis_tdata);
            if (pending_verdicts.size() == 0) begin
                $display("%0t ns: unexpected result word, expected none, got %08h",
                         $time, o_m_axis_tdata);
                n_errors++;
            end else begin
                want_word = pending_verdicts.pop_front();
                check_field("logo_valid", want_word.logo_valid, got_word.logo_valid);
                check_field("checksum_valid", want_word.checksum_valid,
                            got_word.checksum_valid);
                check_field("color_supported", want_word.color_supported,
                            got_word.color_supported);
                check_field("color_exclusive", want_word.color_exclusive,
                            got_word.color_exclusive);
                check_field("super_supported", want_word.super_supported,
                            got_word.super_supported);
                check_field("cart_kind", want_word.cart_kind, got_word.cart_kind);
                check_field("rom_size_kind", want_word.rom_size_kind, got_word.rom_size_kind);
                check_field("ram_size_kind", want_word.ram_size_kind, got_word.ram_size_kind);
                check_field("destination_code", want_word.destination_code,
                            got_word.destination_code);
                check_field("version_number", want_word.version_number,
                            got_word.version_number);
                check_field("cart_supported", want_word.cart_supported,
                            got_word.cart_supported);
            end
        end
    end

    // Watchdog: too long without a word moving on either side.
    initial begin
        forever begin
            @(posedge i_clk);
            if ((s_valid && o_s_axis_tready) || (o_m_axis_tvalid && m_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb_cartridge_header_checker: FAIL");
                $finish;
            end
        end
    end

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < N_DIR; i++)
            send_word(dir_tab[i].addr, dir_tab[i].val, dir_tab[i].last,
                      dir_tab[i].typed, dir_tab[i].want);

        while (n_items < ITEM_TARGET) begin
            gap_pct   = 12 * $urandom_range(0, 3);
            stall_pct = 12 * $urandom_range(0, 3);
            send_random_header($urandom_range(0, 1) == 0);
        end

        // closing stretch at full rate on both sides
        gap_pct   = 0;
        stall_pct = 0;
        repeat (4) send_random_header(1'b1);
        s_valid <= 1'b0;
        s_last  <= 1'b0;

        wait (pending_verdicts.size() == 0);
        repeat (8) @(posedge i_clk);
        if (n_errors == 0)
            $display("tb_cartridge_header_checker: PASS");
        else
            $display("tb_cartridge_header_checker: FAIL");
        $finish;
    end

endmodule
